/* design/lpkv_pkg.sv */
// shared types, codes and constants for the linear-probe key-value table
// no dependencies; every other design file refers to it by scoped names
package lpkv_pkg;

   // default sizing
   localparam int TABLE_BITS_DEF  = 12;
   localparam int PROBE_LIMIT_DEF = 32;
   localparam int VALUE_BITS_DEF  = 64;
   localparam int MAX_TABLE_BITS  = 20;

   // fibonacci hash multiplier, split into 32-bit halves
   localparam logic [63:0] GOLDEN_MULT = 64'd11400714819323198485;
   localparam logic [31:0] GOLDEN_LO   = GOLDEN_MULT[31:0];
   localparam logic [31:0] GOLDEN_HI   = GOLDEN_MULT[63:32];

   // hash takes one 32x32 partial product per step
   localparam int HASH_STEPS  = 3;
   localparam int QUEUE_DEPTH = 2;

   // request kinds
   localparam logic [1:0] KIND_GET = 2'd0;
   localparam logic [1:0] KIND_PUT = 2'd1;

   // result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISS    = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_BADKIND = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] key;
      logic [63:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] value_out;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_GET,
      OP_PUT,
      OP_BAD
   } op_type;

   // classified item handed from front to back
   typedef struct packed {
      op_type                    op;
      logic [63:0]               key;
      logic [63:0]               value;
      logic [MAX_TABLE_BITS-1:0] home;
   } work_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_HASH,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_PROBE,
      B_CHECK,
      B_DONE
   } back_state_type;

endpackage

/* design/lpkv_front.sv */
// front end: accepts requests, classifies the kind, computes the home slot
// depends on lpkv_pkg; uses one shared 32x32 multiplier over three steps
module lpkv_front #(
   parameter int TABLE_BITS = lpkv_pkg::TABLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lpkv_pkg::req_type        req_data,
   input  lpkv_pkg::back_status_type back_status,
   output logic                     push_valid,
   input  logic                     push_full,
   output lpkv_pkg::work_type       push_item
);

   localparam int StepW = $clog2(lpkv_pkg::HASH_STEPS);

   lpkv_pkg::front_state_type state_ff, state_in;
   logic [StepW-1:0]          step_ff, step_in;
   lpkv_pkg::op_type          op_ff;
   logic [63:0]               key_ff;
   logic [63:0]               value_ff;
   logic [31:0]               hi_ff, hi_in;
   logic                      accept;
   logic [31:0]               mul_a, mul_b;
   logic [63:0]               prod;

   assign req_stall = (state_ff != lpkv_pkg::F_IDLE) || back_status.clearing;
   assign accept    = req_valid && !req_stall;

   // operand selection for the partial products that reach the top word
   always_comb begin
      case (step_ff)
         StepW'(0): begin
            mul_a = key_ff[31:0];
            mul_b = lpkv_pkg::GOLDEN_LO;
         end
         StepW'(1): begin
            mul_a = key_ff[63:32];
            mul_b = lpkv_pkg::GOLDEN_LO;
         end
         default: begin
            mul_a = key_ff[31:0];
            mul_b = lpkv_pkg::GOLDEN_HI;
         end
      endcase
      prod = 64'(mul_a) * 64'(mul_b);
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      hi_in      = hi_ff;
      push_valid = 1'b0;
      case (state_ff)
         lpkv_pkg::F_IDLE: begin
            step_in = '0;
            if (accept) begin
               if (req_data.kind inside {lpkv_pkg::KIND_GET, lpkv_pkg::KIND_PUT}) begin
                  state_in = lpkv_pkg::F_HASH;
               end else begin
                  state_in = lpkv_pkg::F_PUSH;
               end
            end
         end
         lpkv_pkg::F_HASH: begin
            if (step_ff == StepW'(0)) begin
               hi_in = prod[63:32];
            end else begin
               hi_in = hi_ff + prod[31:0];
            end
            step_in = StepW'(step_ff + 1'b1);
            if (step_ff == StepW'(lpkv_pkg::HASH_STEPS - 1)) begin
               state_in = lpkv_pkg::F_PUSH;
            end
         end
         lpkv_pkg::F_PUSH: begin
            push_valid = 1'b1;
            if (!push_full) begin
               state_in = lpkv_pkg::F_IDLE;
            end
         end
         default: begin
            state_in = lpkv_pkg::F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpkv_pkg::F_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      if (accept) begin
         key_ff   <= req_data.key;
         value_ff <= req_data.value_in;
         case (req_data.kind)
            lpkv_pkg::KIND_GET: op_ff <= lpkv_pkg::OP_GET;
            lpkv_pkg::KIND_PUT: op_ff <= lpkv_pkg::OP_PUT;
            default:            op_ff <= lpkv_pkg::OP_BAD;
         endcase
      end
   end

   always_comb begin
      push_item.op    = op_ff;
      push_item.key   = key_ff;
      push_item.value = value_ff;
      push_item.home  = lpkv_pkg::MAX_TABLE_BITS'(hi_ff[31 -: TABLE_BITS]);
   end

endmodule

/* design/lpkv_queue.sv */
// short fifo of classified items between front and back
// depends on lpkv_pkg for the item type and depth
module lpkv_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_full,
   input  lpkv_pkg::work_type push_item,
   output logic               pop_valid,
   input  logic               pop,
   output lpkv_pkg::work_type pop_item
);

   localparam int Depth = lpkv_pkg::QUEUE_DEPTH;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   lpkv_pkg::work_type entry_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic               do_push, do_pop;

   assign push_full = (count_ff == CntW'(Depth));
   assign pop_valid = (count_ff != '0);
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop && pop_valid;
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_ff + 1'b1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = CntW'(count_ff + 1'b1);
         2'b01:   count_in = CntW'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* design/lpkv_back.sv */
// back end: slot memory, clearing pass, linear probe sequencer, result register
// depends on lpkv_pkg; one write and one registered read of the memory per cycle
module lpkv_back #(
   parameter int TABLE_BITS  = lpkv_pkg::TABLE_BITS_DEF,
   parameter int PROBE_LIMIT = lpkv_pkg::PROBE_LIMIT_DEF,
   parameter int VALUE_BITS  = lpkv_pkg::VALUE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   output logic                      q_pop,
   input  lpkv_pkg::work_type        q_item,
   output lpkv_pkg::back_status_type back_status,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lpkv_pkg::rsp_type         rsp_data
);

   localparam int Slots = 2 ** TABLE_BITS;
   localparam int EntW  = 1 + 64 + VALUE_BITS;
   localparam int CntW  = $clog2(PROBE_LIMIT + 1);

   // entry layout: used bit, key, value
   logic [EntW-1:0]          mem [Slots];
   logic [EntW-1:0]          rd_ff;

   lpkv_pkg::back_state_type state_ff, state_in;
   logic [TABLE_BITS-1:0]    clr_ff, clr_in;
   logic [TABLE_BITS-1:0]    pos_ff, pos_in;
   logic [CntW-1:0]          cnt_ff, cnt_in;
   lpkv_pkg::op_type         op_ff;
   logic [63:0]              key_ff;
   logic [VALUE_BITS-1:0]    val_ff;
   lpkv_pkg::rsp_type        res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   lpkv_pkg::rsp_type        rsp_data_ff;

   logic                     mem_we;
   logic [TABLE_BITS-1:0]    mem_wa;
   logic [EntW-1:0]          mem_wd;
   logic                     rd_en;
   logic                     load_item;
   logic                     out_load;
   logic                     ent_used;
   logic [63:0]              ent_key;
   logic [VALUE_BITS-1:0]    ent_val;
   logic                     ent_match;
   logic                     last_probe;

   assign ent_used   = rd_ff[EntW-1];
   assign ent_key    = rd_ff[VALUE_BITS +: 64];
   assign ent_val    = rd_ff[VALUE_BITS-1:0];
   assign ent_match  = ent_used && (ent_key == key_ff);
   assign last_probe = (cnt_ff == CntW'(PROBE_LIMIT - 1));

   assign back_status.clearing = (state_ff == lpkv_pkg::B_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_wa    = pos_ff;
      mem_wd    = '0;
      rd_en     = 1'b0;
      q_pop     = 1'b0;
      load_item = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         lpkv_pkg::B_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = TABLE_BITS'(clr_ff + 1'b1);
            if (clr_ff == '1) begin
               state_in = lpkv_pkg::B_IDLE;
            end
         end
         lpkv_pkg::B_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               load_item = 1'b1;
               pos_in    = q_item.home[TABLE_BITS-1:0];
               cnt_in    = '0;
               if (q_item.op == lpkv_pkg::OP_BAD) begin
                  res_in.status    = lpkv_pkg::ST_BADKIND;
                  res_in.value_out = '0;
                  state_in         = lpkv_pkg::B_DONE;
               end else begin
                  state_in = lpkv_pkg::B_PROBE;
               end
            end
         end
         lpkv_pkg::B_PROBE: begin
            rd_en    = 1'b1;
            state_in = lpkv_pkg::B_CHECK;
         end
         lpkv_pkg::B_CHECK: begin
            res_in.value_out = '0;
            if (op_ff == lpkv_pkg::OP_GET) begin
               if (!ent_used) begin
                  res_in.status = lpkv_pkg::ST_MISS;
                  state_in      = lpkv_pkg::B_DONE;
               end else if (ent_match) begin
                  res_in.status    = lpkv_pkg::ST_OK;
                  res_in.value_out = 64'(ent_val);
                  state_in         = lpkv_pkg::B_DONE;
               end else if (last_probe) begin
                  res_in.status = lpkv_pkg::ST_MISS;
                  state_in      = lpkv_pkg::B_DONE;
               end else begin
                  pos_in   = TABLE_BITS'(pos_ff + 1'b1);
                  cnt_in   = CntW'(cnt_ff + 1'b1);
                  state_in = lpkv_pkg::B_PROBE;
               end
            end else begin
               if (!ent_used || ent_match) begin
                  mem_we        = 1'b1;
                  mem_wd        = {1'b1, key_ff, val_ff};
                  res_in.status = lpkv_pkg::ST_OK;
                  state_in      = lpkv_pkg::B_DONE;
               end else if (last_probe) begin
                  res_in.status = lpkv_pkg::ST_FULL;
                  state_in      = lpkv_pkg::B_DONE;
               end else begin
                  pos_in   = TABLE_BITS'(pos_ff + 1'b1);
                  cnt_in   = CntW'(cnt_ff + 1'b1);
                  state_in = lpkv_pkg::B_PROBE;
               end
            end
         end
         lpkv_pkg::B_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = lpkv_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = lpkv_pkg::B_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpkv_pkg::B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
      if (load_item) begin
         op_ff  <= q_item.op;
         key_ff <= q_item.key;
         val_ff <= q_item.value[VALUE_BITS-1:0];
      end
      if (out_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_ff <= mem[pos_ff];
      end
   end

endmodule

/* design/linear_probe_key_value_table.sv */
// steps: accept, hash, queue push, then pop, read and check per probed slot, result
// the back takes one item at a time; each probed slot is read, then checked
// the front hashes the next item while the back probes; the memory's single registered
// read port sets the probe rate
// reset: synchronous; a clearing pass over all 2^TABLE_BITS slots wipes the slot memory,
// during which req_stall stays high
module linear_probe_key_value_table #(
   parameter int TABLE_BITS  = lpkv_pkg::TABLE_BITS_DEF,
   parameter int PROBE_LIMIT = lpkv_pkg::PROBE_LIMIT_DEF,
   parameter int VALUE_BITS  = lpkv_pkg::VALUE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  lpkv_pkg::req_type req_data,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lpkv_pkg::rsp_type rsp_data
);

   // front to queue
   logic                      push_valid;
   logic                      push_full;
   lpkv_pkg::work_type        push_item;
   // queue to back
   logic                      q_valid;
   logic                      q_pop;
   lpkv_pkg::work_type        q_item;
   // back tells front when the memory is being cleared
   lpkv_pkg::back_status_type back_status;

   // classify the kind and compute the fibonacci home slot
   lpkv_front #(
      .TABLE_BITS (TABLE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .back_status (back_status),
      .push_valid  (push_valid),
      .push_full   (push_full),
      .push_item   (push_item)
   );

   // decouples hashing from probing
   lpkv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_item  (push_item),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_item   (q_item)
   );

   // walks the probe window and owns the result register
   lpkv_back #(
      .TABLE_BITS  (TABLE_BITS),
      .PROBE_LIMIT (PROBE_LIMIT),
      .VALUE_BITS  (VALUE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_item      (q_item),
      .back_status (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

/* design/lpkv_checker.sv */
// port-level checks for the key-value table, attached by bind
// depends on lpkv_pkg and linear_probe_key_value_table
module lpkv_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input lpkv_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lpkv_pkg::rsp_type rsp_data
);

   // a stalled item holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   // a stalled request stays offered unchanged
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request item changed");

   // a result that is not ok carries a zero value
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != lpkv_pkg::ST_OK |-> rsp_data.value_out == 64'd0)
      else $error("non-ok result with nonzero value");

   // no item is taken right after reset while the memory clears
   a_clear_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request accepted during clearing pass");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind linear_probe_key_value_table lpkv_checker u_lpkv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
